[design/dr3d_pkg.sv]
// Package with shared constants, types and arithmetic helpers of the dead-reckoning step.
package dr3d_pkg;

   localparam int POS_WIDTH_DEF = 40;

   // Field widths of one input item and one result item.
   localparam int TIME_W  = 48;
   localparam int YAW_W   = 20;
   localparam int SPD_W   = 18;
   localparam int ANG_W   = 18;
   localparam int THR_W   = 17;
   localparam int CSR_W   = 17;

   // CORDIC working widths (Q20 angles and coordinates).
   localparam int XW       = 24;
   localparam int ZW       = 25;
   localparam int NLANE    = 2;
   localparam int CORDIC_N = 20;
   localparam int CNT_W    = 5;

   // Shared multiplier and position increment widths.
   localparam int MUL_W  = 30;
   localparam int PROD_W = 2 * MUL_W;
   localparam int INC_W  = 48;

   localparam logic signed [ZW-1:0] Q20_PI      = 25'sd3294199;
   localparam logic signed [ZW-1:0] Q20_HALF_PI = 25'sd1647099;
   localparam logic signed [ZW-1:0] Q20_TWO_PI  = 25'sd6588398;
   localparam logic signed [XW-1:0] CORDIC_GAIN = 24'sd636751;
   localparam logic signed [PROD_W-1:0] HALF_Q20 = 60'sd524288;

   // Configuration register indexes.
   localparam logic CSR_REVERSE_MOUNT = 1'b0;
   localparam logic CSR_STOP_THRESH   = 1'b1;

   // Steps of the multiply sequence. Each step starts one product and
   // consumes the product started in the step before.
   localparam logic [CNT_W-1:0] MS_SHCP = 5'd0;
   localparam logic [CNT_W-1:0] MS_CHCP = 5'd1;
   localparam logic [CNT_W-1:0] MS_E    = 5'd2;
   localparam logic [CNT_W-1:0] MS_N    = 5'd3;
   localparam logic [CNT_W-1:0] MS_U    = 5'd4;
   localparam logic [CNT_W-1:0] MS_EHI  = 5'd5;
   localparam logic [CNT_W-1:0] MS_ELO  = 5'd6;
   localparam logic [CNT_W-1:0] MS_NHI  = 5'd7;
   localparam logic [CNT_W-1:0] MS_NLO  = 5'd8;
   localparam logic [CNT_W-1:0] MS_UHI  = 5'd9;
   localparam logic [CNT_W-1:0] MS_ULO  = 5'd10;
   localparam logic [CNT_W-1:0] MS_UINC = 5'd11;
   localparam logic [CNT_W-1:0] MS_UPOS = 5'd12;
   localparam logic [CNT_W-1:0] CORDIC_LAST = 5'd19;

   typedef struct packed {
      logic             load;
      logic             cordic_en;
      logic             mul_en;
      logic [CNT_W-1:0] cnt;
      logic             out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic armed;
      logic pos_en;
   } ctl_status_type;

   typedef struct packed {
      logic                 neg;
      logic signed [ZW-1:0] z;
   } cordic_init_type;

   function automatic logic signed [ZW-1:0] atan_q20(input logic [CNT_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:    r = 25'sd823550;
         5'd1:    r = 25'sd486170;
         5'd2:    r = 25'sd256879;
         5'd3:    r = 25'sd130396;
         5'd4:    r = 25'sd65451;
         5'd5:    r = 25'sd32757;
         5'd6:    r = 25'sd16383;
         5'd7:    r = 25'sd8192;
         5'd8:    r = 25'sd4096;
         5'd9:    r = 25'sd2048;
         5'd10:   r = 25'sd1024;
         5'd11:   r = 25'sd512;
         5'd12:   r = 25'sd256;
         5'd13:   r = 25'sd128;
         5'd14:   r = 25'sd64;
         5'd15:   r = 25'sd32;
         5'd16:   r = 25'sd16;
         5'd17:   r = 25'sd8;
         5'd18:   r = 25'sd4;
         5'd19:   r = 25'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Scale to Q20, wrap once into [-pi, pi] and fold into [-pi/2, pi/2].
   function automatic cordic_init_type cordic_prep(input logic signed [ANG_W-1:0] ang);
      cordic_init_type r;
      logic signed [ZW-1:0] z;
      z = ZW'(ang) <<< 5;
      if (z > Q20_PI) z = z - Q20_TWO_PI;
      if (z < -Q20_PI) z = z + Q20_TWO_PI;
      r.neg = 1'b0;
      if (z > Q20_HALF_PI) begin
         z = z - Q20_PI;
         r.neg = 1'b1;
      end else if (z < -Q20_HALF_PI) begin
         z = z + Q20_PI;
         r.neg = 1'b1;
      end
      r.z = z;
      return r;
   endfunction

   function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [PROD_W-21:0] v);
      logic signed [SPD_W-1:0] r;
      if (v > 40'sd131071) r = 18'sh1FFFF;
      else if (v < -40'sd131072) r = 18'sh20000;
      else r = v[SPD_W-1:0];
      return r;
   endfunction

   function automatic logic signed [YAW_W-1:0] sat_yaw(input logic signed [YAW_W+1:0] v);
      logic signed [YAW_W-1:0] r;
      if (v > 22'sd524287) r = 20'sh7FFFF;
      else if (v < -22'sd524288) r = 20'sh80000;
      else r = v[YAW_W-1:0];
      return r;
   endfunction

endpackage

[design/dr3d_ctrl.sv]
// Sequencer of the dead-reckoning step: accept, CORDIC iterations and multiply steps (once armed), output.
module dr3d_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  dr3d_pkg::ctl_status_type status,
   output dr3d_pkg::ctl_cmd_type    cmd
);
   import dr3d_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CORDIC = 2'd1;
   localparam logic [1:0] S_MUL    = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vld_ff, vld_in;
   logic             accept;
   logic             out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !vld_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vld_in       = vld_ff && !rsp_tready;
      cmd          = '0;
      cmd.cnt      = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = status.armed ? S_CORDIC : S_DONE;
            end
         end
         S_CORDIC: begin
            cmd.cordic_en = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == (status.pos_en ? MS_UPOS : MS_EHI)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               vld_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

[design/dr3d_datapath.sv]
// Datapath of the dead-reckoning step: yaw correction, CORDIC lanes, shared multiplier, state.
module dr3d_datapath #(
   parameter int POS_WIDTH = dr3d_pkg::POS_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [dr3d_pkg::CSR_W-1:0]            csr_wdata,
   input  dr3d_pkg::ctl_cmd_type                 cmd,
   output dr3d_pkg::ctl_status_type              status,
   input  logic [dr3d_pkg::TIME_W-1:0]           sample_time,
   input  logic signed [dr3d_pkg::YAW_W-1:0]     raw_yaw_rate,
   input  logic signed [dr3d_pkg::SPD_W-1:0]     speed,
   input  logic                                  speed_valid,
   input  logic signed [dr3d_pkg::ANG_W-1:0]     heading,
   input  logic                                  heading_valid,
   input  logic signed [dr3d_pkg::ANG_W-1:0]     pitch,
   input  logic signed [dr3d_pkg::YAW_W-1:0]     moving_offset,
   input  logic                                  moving_offset_valid,
   input  logic signed [dr3d_pkg::YAW_W-1:0]     stopped_offset,
   output logic signed [dr3d_pkg::YAW_W-1:0]     yaw_rate_out,
   output logic signed [dr3d_pkg::SPD_W-1:0]     speed_out,
   output logic signed [dr3d_pkg::SPD_W-1:0]     vel_east,
   output logic signed [dr3d_pkg::SPD_W-1:0]     vel_north,
   output logic signed [dr3d_pkg::SPD_W-1:0]     vel_up,
   output logic signed [POS_WIDTH-1:0]           pos_east,
   output logic signed [POS_WIDTH-1:0]           pos_north,
   output logic signed [POS_WIDTH-1:0]           pos_up,
   output logic                                  pos_valid
);
   import dr3d_pkg::*;

   localparam int SUM_W = ((POS_WIDTH > INC_W) ? POS_WIDTH : INC_W) + 1;

   // Configuration and persistent state.
   logic                     rev_ff;
   logic [THR_W-1:0]         thr_ff;
   logic [1:0]               sc_ff, sc_in;
   logic [TIME_W-1:0]        last_ff;
   logic signed [SPD_W-1:0]  vel_ff [3];
   logic signed [POS_WIDTH-1:0] pos_ff [3];
   logic                     pv_ff;

   // Per-item working registers.
   logic signed [YAW_W-1:0]  yaw_ff;
   logic signed [SPD_W-1:0]  spd_ff;
   logic [TIME_W-1:0]        adt_ff;
   logic                     dtneg_ff;
   logic                     posen_ff;
   logic signed [XW-1:0]     cx_ff [NLANE];
   logic signed [XW-1:0]     cy_ff [NLANE];
   logic signed [ZW-1:0]     cz_ff [NLANE];
   logic                     cneg_ff [NLANE];
   logic signed [XW-1:0]     cx_in [NLANE];
   logic signed [XW-1:0]     cy_in [NLANE];
   logic signed [ZW-1:0]     cz_in [NLANE];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [XW-1:0]     te_ff, tn_ff;
   logic [INC_W-1:0]         ph_ff;
   logic                     sgn_ff;
   logic signed [INC_W-1:0]  inc_ff;

   // Output registers.
   logic signed [YAW_W-1:0]     o_yaw_ff;
   logic signed [SPD_W-1:0]     o_spd_ff;
   logic signed [SPD_W-1:0]     o_vel_ff [3];
   logic signed [POS_WIDTH-1:0] o_pos_ff [3];
   logic                        o_pv_ff;

   // Combinational signals.
   logic signed [SPD_W:0]    spd_x;
   logic                     moving;
   logic signed [YAW_W+1:0]  yaw_sum;
   logic signed [TIME_W:0]   dt;
   cordic_init_type          ini_h, ini_p;
   logic signed [XW-1:0]     sh, ch, sp, cp;
   logic [1:0]               vaxis, paxis;
   logic signed [SPD_W-1:0]  vsel;
   logic [SPD_W-1:0]         av;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [PROD_W-21:0] q;
   logic [INC_W-1:0]         mag;
   logic signed [SUM_W-1:0]  sum;
   logic signed [POS_WIDTH-1:0] pos_sat;

   // Yaw correction and start counter, evaluated on the item being accepted.
   assign spd_x   = (SPD_W+1)'(speed);
   assign moving  = spd_x > $signed({2'b00, thr_ff});
   assign yaw_sum = (rev_ff ? (YAW_W+2)'(raw_yaw_rate) : -(YAW_W+2)'(raw_yaw_rate))
                  + ((moving && moving_offset_valid) ? (YAW_W+2)'(moving_offset)
                                                     : (YAW_W+2)'(stopped_offset));
   assign dt      = $signed({1'b0, sample_time}) - $signed({1'b0, last_ff});
   assign ini_h   = cordic_prep(heading);
   assign ini_p   = cordic_prep(pitch);

   always_comb begin
      sc_in = sc_ff;
      if (sc_ff == 2'd0 && speed_valid && heading_valid) sc_in = 2'd1;
      else if (sc_ff == 2'd1) sc_in = 2'd2;
   end

   assign status.armed  = (sc_in == 2'd2);
   assign status.pos_en = posen_ff;

   // One rotation step on both lanes (lane 0 heading, lane 1 pitch).
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         if (cz_ff[l] >= 0) begin
            cx_in[l] = cx_ff[l] - (cy_ff[l] >>> cmd.cnt);
            cy_in[l] = cy_ff[l] + (cx_ff[l] >>> cmd.cnt);
            cz_in[l] = cz_ff[l] - atan_q20(cmd.cnt);
         end else begin
            cx_in[l] = cx_ff[l] + (cy_ff[l] >>> cmd.cnt);
            cy_in[l] = cy_ff[l] - (cx_ff[l] >>> cmd.cnt);
            cz_in[l] = cz_ff[l] + atan_q20(cmd.cnt);
         end
      end
   end

   assign sh = cneg_ff[0] ? -cy_ff[0] : cy_ff[0];
   assign ch = cneg_ff[0] ? -cx_ff[0] : cx_ff[0];
   assign sp = cneg_ff[1] ? -cy_ff[1] : cy_ff[1];
   assign cp = cneg_ff[1] ? -cx_ff[1] : cx_ff[1];

   always_comb begin
      case (cmd.cnt)
         MS_EHI, MS_ELO: vaxis = 2'd0;
         MS_NHI, MS_NLO: vaxis = 2'd1;
         default:        vaxis = 2'd2;
      endcase
      case (cmd.cnt)
         MS_NLO:  paxis = 2'd0;
         MS_ULO:  paxis = 2'd1;
         default: paxis = 2'd2;
      endcase
   end

   assign vsel = vel_ff[vaxis];
   assign av   = vsel[SPD_W-1] ? SPD_W'(-vsel) : SPD_W'(vsel);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.cnt)
         MS_SHCP: begin mul_a = MUL_W'(sh);    mul_b = MUL_W'(cp); end
         MS_CHCP: begin mul_a = MUL_W'(ch);    mul_b = MUL_W'(cp); end
         MS_E:    begin mul_a = MUL_W'(spd_ff); mul_b = MUL_W'(te_ff); end
         MS_N:    begin mul_a = MUL_W'(spd_ff); mul_b = MUL_W'(tn_ff); end
         MS_U:    begin mul_a = MUL_W'(spd_ff); mul_b = MUL_W'(sp); end
         MS_EHI, MS_NHI, MS_UHI: begin
            mul_a = $signed({{(MUL_W-SPD_W){1'b0}}, av});
            mul_b = $signed({{(MUL_W-TIME_W+20){1'b0}}, adt_ff[TIME_W-1:20]});
         end
         MS_ELO, MS_NLO, MS_ULO: begin
            mul_a = $signed({{(MUL_W-SPD_W){1'b0}}, av});
            mul_b = $signed({{(MUL_W-20){1'b0}}, adt_ff[19:0]});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_rnd = prod_ff + HALF_Q20;
   assign q        = prod_rnd[PROD_W-1:20];
   assign mag      = ph_ff + INC_W'(q);
   assign sum      = SUM_W'(pos_ff[paxis]) + SUM_W'(inc_ff);

   // Saturate to POS_WIDTH signed bits: overflow when the top bits disagree.
   always_comb begin
      if (sum[SUM_W-1:POS_WIDTH-1] == '0 || sum[SUM_W-1:POS_WIDTH-1] == '1) begin
         pos_sat = sum[POS_WIDTH-1:0];
      end else if (sum[SUM_W-1]) begin
         pos_sat = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         pos_sat = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   end

   // State with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff  <= 1'b0;
         thr_ff  <= THR_W'(10);
         sc_ff   <= '0;
         last_ff <= '0;
         pv_ff   <= 1'b0;
         o_pv_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            vel_ff[k] <= '0;
            pos_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_REVERSE_MOUNT: rev_ff <= csr_wdata[0];
               CSR_STOP_THRESH:   thr_ff <= csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            sc_ff   <= sc_in;
            last_ff <= sample_time;
         end
         if (cmd.mul_en) begin
            case (cmd.cnt)
               MS_N:    vel_ff[0] <= sat_spd(q);
               MS_U:    vel_ff[1] <= sat_spd(q);
               MS_EHI:  vel_ff[2] <= sat_spd(q);
               MS_NLO, MS_ULO: pos_ff[paxis] <= pos_sat;
               MS_UPOS: begin
                  pos_ff[paxis] <= pos_sat;
                  pv_ff         <= 1'b1;
               end
               default: ;
            endcase
         end
         if (cmd.out_load) o_pv_ff <= pv_ff;
      end
   end

   // Working and output payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yaw_ff     <= sat_yaw(yaw_sum);
         spd_ff     <= speed;
         dtneg_ff   <= dt[TIME_W];
         adt_ff     <= dt[TIME_W] ? TIME_W'(-dt) : dt[TIME_W-1:0];
         posen_ff   <= (sc_in == 2'd2) && (speed > 0) && (last_ff != '0);
         cx_ff[0]   <= CORDIC_GAIN;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= ini_h.z;
         cneg_ff[0] <= ini_h.neg;
         cx_ff[1]   <= CORDIC_GAIN;
         cy_ff[1]   <= '0;
         cz_ff[1]   <= ini_p.z;
         cneg_ff[1] <= ini_p.neg;
      end else if (cmd.cordic_en) begin
         for (int l = 0; l < NLANE; l++) begin
            cx_ff[l] <= cx_in[l];
            cy_ff[l] <= cy_in[l];
            cz_ff[l] <= cz_in[l];
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
         case (cmd.cnt)
            MS_CHCP: te_ff <= q[XW-1:0];
            MS_E:    tn_ff <= q[XW-1:0];
            MS_ELO, MS_NLO, MS_ULO: begin
               ph_ff  <= prod_ff[INC_W-1:0];
               sgn_ff <= vsel[SPD_W-1] != dtneg_ff;
            end
            MS_NHI, MS_UHI, MS_UINC: inc_ff <= sgn_ff ? -$signed(mag) : $signed(mag);
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         o_yaw_ff <= yaw_ff;
         o_spd_ff <= spd_ff;
         for (int k = 0; k < 3; k++) begin
            o_vel_ff[k] <= vel_ff[k];
            o_pos_ff[k] <= pos_ff[k];
         end
      end
   end

   assign yaw_rate_out = o_yaw_ff;
   assign speed_out    = o_spd_ff;
   assign vel_east     = o_vel_ff[0];
   assign vel_north    = o_vel_ff[1];
   assign vel_up       = o_vel_ff[2];
   assign pos_east     = o_pos_ff[0];
   assign pos_north    = o_pos_ff[1];
   assign pos_up       = o_pos_ff[2];
   assign pos_valid    = o_pv_ff;

endmodule

[design/dead_reckoning_3d_step.sv]
// Top level of the dead-reckoning step: stream ports, sequencer and datapath.
//
// Each accepted item is one IMU sample; it produces exactly one result item holding the
// offset-corrected yaw rate, the speed, the held East/North/Up velocity, the saturating
// relative position and a flag that is set once a position step has happened. The block
// works on one item at a time. Until the start counter is armed, the output register is
// loaded from the done state as soon as it is free, and the next item can be taken after
// that. Once armed, two 20-step CORDIC lanes (heading and pitch) run side by side, then
// one shared 30x30 multiplier runs 6 steps for the velocities, or 13 steps when a position
// step is also due, followed by the load of the output register once it is free. How long
// an armed item occupies the block is set by the CORDIC iterations and the single
// multiplier. The result sits in an output register, so a new item is accepted while the
// previous result still waits to be taken. Configuration writes land at once and are meant
// to be made while the block is idle.
module dead_reckoning_3d_step #(
   parameter int POS_WIDTH = dr3d_pkg::POS_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Input item: sample_time, raw_yaw_rate, speed, heading, pitch,
   // moving_offset, stopped_offset, zero fill.
   input  logic [167:0] req_tdata,
   // Input flags: speed_valid, heading_valid, moving_offset_valid.
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Result item: yaw_rate_out, speed_out, vel_east, vel_north, vel_up,
   // pos_east, pos_north, pos_up, zero fill.
   output logic [((92 + 3 * POS_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Result flag: pos_valid.
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [16:0]  csr_wdata
);
   import dr3d_pkg::*;

   localparam int RSP_BITS = 92 + 3 * POS_WIDTH;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   logic signed [YAW_W-1:0]     yaw_rate_out;
   logic signed [SPD_W-1:0]     speed_out, vel_east, vel_north, vel_up;
   logic signed [POS_WIDTH-1:0] pos_east, pos_north, pos_up;
   logic                        pos_valid;

   dr3d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dr3d_datapath #(
      .POS_WIDTH (POS_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .sample_time         (req_tdata[47:0]),
      .raw_yaw_rate        ($signed(req_tdata[67:48])),
      .speed               ($signed(req_tdata[85:68])),
      .speed_valid         (req_tuser[0]),
      .heading             ($signed(req_tdata[103:86])),
      .heading_valid       (req_tuser[1]),
      .pitch               ($signed(req_tdata[121:104])),
      .moving_offset       ($signed(req_tdata[141:122])),
      .moving_offset_valid (req_tuser[2]),
      .stopped_offset      ($signed(req_tdata[161:142])),
      .yaw_rate_out        (yaw_rate_out),
      .speed_out           (speed_out),
      .vel_east            (vel_east),
      .vel_north           (vel_north),
      .vel_up              (vel_up),
      .pos_east            (pos_east),
      .pos_north           (pos_north),
      .pos_up              (pos_up),
      .pos_valid           (pos_valid)
   );

   assign rsp_tdata = RSP_W'({pos_up, pos_north, pos_east, vel_up, vel_north, vel_east,
                              speed_out, yaw_rate_out});
   assign rsp_tuser = pos_valid;

`ifndef SYNTHESIS
   // One item at a time: right after an acceptance the input side is closed.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is still in work");

   // The position flag never falls once a position step has been reported.
   a_pos_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tuser[0]) |-> rsp_tuser[0])
      else $error("pos_valid fell without reset");

   // A new result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten before it was taken");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench of the dead-reckoning step: stimulus, prediction and result checks.
module testbench;
   import dr3d_pkg::*;

   localparam int POS_W  = POS_WIDTH_DEF;
   localparam int RSP_DW = ((92 + 3 * POS_W + 7) / 8) * 8;

   // One IMU sample as the sender sees it.
   typedef struct {
      logic [TIME_W-1:0]       t;
      logic signed [YAW_W-1:0] raw;
      logic signed [SPD_W-1:0] spd;
      logic                    spd_ok;
      logic signed [ANG_W-1:0] hdg;
      logic                    hdg_ok;
      logic signed [ANG_W-1:0] pit;
      logic signed [YAW_W-1:0] moff;
      logic                    moff_ok;
      logic signed [YAW_W-1:0] soff;
   } imu_sample_type;

   // One navigation result, every field held sign-extended to 64 bits.
   typedef struct {
      longint yaw;
      longint spd;
      longint vel [3];
      longint pos [3];
      longint pv;
   } nav_result_type;

   logic                clock;
   logic                reset;
   logic [167:0]        req_tdata;
   logic [2:0]          req_tuser;
   logic                req_tvalid;
   logic                req_tready;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic                csr_we;
   logic                csr_index;
   logic [16:0]         csr_wdata;

   dead_reckoning_3d_step #(.POS_WIDTH(POS_W)) dut (.*);

   // Predicted navigation results, oldest first.
   nav_result_type pending_nav[$];
   int             fail_count = 0;

   // Shadow of the block's configuration and state.
   bit          mdl_reverse;
   longint      mdl_thresh;
   int          mdl_start;
   longint      mdl_last_t;
   longint      mdl_vel [3];
   longint      mdl_pos [3];
   longint      mdl_pv;

   // Sender pacing: items left in the current burst.
   int          burst_left = 0;
   // Running timestamp for well-formed sample sequences.
   longint      time_cursor = 1000;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run must end long before this; hitting it means the block hung.
   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Rotation-mode CORDIC on a 2^-15 rad angle; sine and cosine come out in Q20.
   function automatic void cordic_sincos(longint ang, output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      longint atan_tab [20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      bit     flip;
      z = ang * 32;
      x = 636751;
      y = 0;
      flip = 1'b0;
      if (z > 3294199) z -= 6588398;
      if (z < -3294199) z += 6588398;
      if (z > 1647099) begin
         z -= 3294199;
         flip = 1'b1;
      end else if (z < -1647099) begin
         z += 3294199;
         flip = 1'b1;
      end
      for (int i = 0; i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function automatic longint q20_mul(longint a, longint b);
      return (a * b + 524288) >>> 20;
   endfunction

   // Distance moved in one step, rounded half away from zero.
   function automatic longint step_distance(longint v, longint dt);
      longint av, ad, mag;
      av = v < 0 ? -v : v;
      ad = dt < 0 ? -dt : dt;
      mag = av * (ad >>> 20) + ((av * (ad & 64'hFFFFF) + 524288) >>> 20);
      return ((v < 0) != (dt < 0)) ? -mag : mag;
   endfunction

   // Advances the shadow state by one sample and gives the result it must produce.
   function automatic nav_result_type predict_nav(imu_sample_type s);
      nav_result_type r;
      longint spd, yaw, sh, ch, sp, cp, dt, pmax, np;
      bit     moving;
      spd = s.spd;
      moving = spd > mdl_thresh;
      yaw = (mdl_reverse ? longint'(s.raw) : -longint'(s.raw))
            + ((moving && s.moff_ok) ? longint'(s.moff) : longint'(s.soff));
      r.yaw = clamp(yaw, -524288, 524287);
      if (mdl_start == 0 && s.spd_ok && s.hdg_ok) mdl_start = 1;
      else if (mdl_start == 1) mdl_start = 2;
      if (mdl_start == 2) begin
         cordic_sincos(s.hdg, sh, ch);
         cordic_sincos(s.pit, sp, cp);
         mdl_vel[0] = clamp(q20_mul(spd, q20_mul(sh, cp)), -131072, 131071);
         mdl_vel[1] = clamp(q20_mul(spd, q20_mul(ch, cp)), -131072, 131071);
         mdl_vel[2] = clamp(q20_mul(spd, sp), -131072, 131071);
         if (spd > 0 && mdl_last_t != 0) begin
            dt = longint'(s.t) - mdl_last_t;
            pmax = (64'sd1 <<< (POS_W - 1)) - 1;
            for (int k = 0; k < 3; k++) begin
               // The sum cannot overflow 64 bits at these widths.
               np = mdl_pos[k] + step_distance(mdl_vel[k], dt);
               mdl_pos[k] = clamp(np, -pmax - 1, pmax);
            end
            mdl_pv = 1;
         end
      end
      mdl_last_t = s.t;
      r.spd = spd;
      for (int k = 0; k < 3; k++) begin
         r.vel[k] = mdl_vel[k];
         r.pos[k] = mdl_pos[k];
      end
      r.pv = mdl_pv;
      return r;
   endfunction

   // Sends one sample, pacing the sender in bursts with random gaps between them.
   task automatic send_sample(imu_sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tdata  = {6'd0, s.soff, s.moff, s.pit, s.hdg, s.spd, s.raw, s.t};
      req_tuser  = {s.moff_ok, s.hdg_ok, s.spd_ok};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_nav.push_back(predict_nav(s));
   endtask

   // Stops sending and waits until every predicted result has been taken.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_nav.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [16:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_REVERSE_MOUNT) mdl_reverse = val[0];
      else mdl_thresh = val;
   endtask

   function automatic imu_sample_type make_sample(longint t, longint raw, longint spd,
                                                  bit sv, longint hdg, bit hv, longint pit,
                                                  longint moff, bit mv, longint soff);
      imu_sample_type s;
      s.t = TIME_W'(t); s.raw = YAW_W'(raw); s.spd = SPD_W'(spd); s.spd_ok = sv;
      s.hdg = ANG_W'(hdg); s.hdg_ok = hv; s.pit = ANG_W'(pit); s.moff = YAW_W'(moff);
      s.moff_ok = mv; s.soff = YAW_W'(soff);
      return s;
   endfunction

   // Random sample: mostly a plausible drive with advancing time, the rest noise.
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      s.t      = TIME_W'({$urandom, $urandom});
      s.raw    = YAW_W'($urandom);
      s.spd    = SPD_W'($urandom);
      s.hdg    = ANG_W'($urandom);
      s.pit    = ANG_W'($urandom);
      s.moff   = YAW_W'($urandom);
      s.soff   = YAW_W'($urandom);
      s.spd_ok = 1'($urandom_range(0, 1));
      s.hdg_ok = 1'($urandom_range(0, 1));
      s.moff_ok = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
         case ($urandom_range(0, 5))
            0: time_cursor -= $urandom_range(0, 2000);    // time stepping back
            1: time_cursor += $urandom_range(0, 50000000);
            default: time_cursor += $urandom_range(1, 150000);
         endcase
         if (time_cursor < 0) time_cursor = 1;
         s.t = TIME_W'(time_cursor);
         s.spd_ok = ($urandom_range(0, 19) != 0);
         s.hdg_ok = ($urandom_range(0, 19) != 0);
         case ($urandom_range(0, 3))
            0: s.spd = SPD_W'(mdl_thresh + $urandom_range(0, 2) - 1);
            1: s.spd = SPD_W'($urandom_range(0, 40000));
            2: s.spd = SPD_W'(-longint'($urandom_range(0, 3000)));
            default: ;
         endcase
      end
      return s;
   endfunction

   // Receiver: alternates free-running stretches with random and long stalls.
   initial begin
      int mode, left;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         left = $urandom_range(5, 200);
         while (left > 0) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = $urandom_range(0, 1);
               2: rsp_tready = ($urandom_range(0, 7) == 0);
               default: rsp_tready = ($urandom_range(0, 30) != 0) ? 1'b0 : 1'b1;
            endcase
            left--;
         end
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Every taken result is compared with the oldest prediction.
   always @(posedge clock) begin
      nav_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_nav.size() == 0) begin
            $error("result item arrived with no prediction waiting");
            fail_count++;
         end else begin
            e = pending_nav.pop_front();
            check_field("yaw_rate_out", e.yaw, $signed(rsp_tdata[19:0]));
            check_field("speed_out", e.spd, $signed(rsp_tdata[37:20]));
            check_field("vel_east", e.vel[0], $signed(rsp_tdata[55:38]));
            check_field("vel_north", e.vel[1], $signed(rsp_tdata[73:56]));
            check_field("vel_up", e.vel[2], $signed(rsp_tdata[91:74]));
            check_field("pos_east", e.pos[0], $signed(rsp_tdata[92 +: POS_W]));
            check_field("pos_north", e.pos[1], $signed(rsp_tdata[92 + POS_W +: POS_W]));
            check_field("pos_up", e.pos[2], $signed(rsp_tdata[92 + 2 * POS_W +: POS_W]));
            check_field("pos_valid", e.pv, rsp_tuser[0]);
         end
      end
   end

   // Directed samples: startup, extremes, zero and backward time, saturation.
   task automatic test_directed();
      longint tmax;
      tmax = (64'd1 << 48) - 1;
      // Not armed: flags off, velocity and position must hold at zero.
      send_sample(make_sample(100, 524287, 5000, 0, 0, 1, 0, 524287, 1, 0));
      send_sample(make_sample(200, -524288, 5000, 1, 0, 0, 0, 0, 1, -524288));
      // Arming takes the valid sample plus one more.
      send_sample(make_sample(300, 1000, 11, 1, 1000, 1, 0, 7, 1, 3));
      send_sample(make_sample(0, -524288, 10, 1, 131071, 1, -131072, 524287, 1, 0));
      // last_time is zero here, so no position step yet.
      send_sample(make_sample(1048576, 524287, 131071, 1, -131072, 1, 131071,
                              -524288, 0, -524288));
      send_sample(make_sample(2097152, 0, 131071, 1, 51472, 1, 0, 0, 1, 524287));
      // Time runs backwards: position moves back.
      send_sample(make_sample(1000000, 12345, 20000, 1, -51472, 1, 25000, 100, 1, -100));
      send_sample(make_sample(1000500, -1, 0, 1, 102943, 1, -25000, 0, 0, 0));
      send_sample(make_sample(1001000, 1, -131072, 1, -102943, 1, 0, 0, 1, 0));
      // Huge jumps in time drive every position into saturation both ways.
      send_sample(make_sample(tmax, 0, 131071, 0, 25736, 0, 25736, 0, 1, 0));
      send_sample(make_sample(1, 0, 131071, 1, 25736, 1, 25736, 0, 1, 0));
      send_sample(make_sample(tmax, 0, 131071, 1, -77208, 1, -25736, 0, 1, 0));
      send_sample(make_sample(2, 0, 131071, 1, -77208, 1, -25736, 0, 1, 0));
      send_sample(make_sample(tmax, 0, 131071, 1, 77208, 1, 51472, 0, 1, 0));
      send_sample(make_sample(tmax - 1048576, 0, 131071, 1, 77208, 1, 51472, 0, 1, 0));
      drain_results();
   endtask

   // Register extremes: each setting is followed by a random drive.
   task automatic test_settings();
      logic [16:0] thr_set [4] = '{17'd0, 17'd131071, 17'd10, 17'd2000};
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_REVERSE_MOUNT, (p % 2 == 0) ? 17'd1 : 17'd0);
         write_csr(CSR_STOP_THRESH, thr_set[p]);
         repeat (80) send_sample(random_sample());
         drain_results();
      end
   endtask

   // Long random drive under varied settings, with one full hold-off halfway.
   task automatic test_random_drive();
      for (int n = 0; n < 1000; n++) begin
         if (n % 250 == 249) begin
            drain_results();
            write_csr(CSR_REVERSE_MOUNT, 17'($urandom_range(0, 1)));
            write_csr(CSR_STOP_THRESH, 17'($urandom_range(0, 3000)));
         end
         if (n == 500) drain_results();
         send_sample(random_sample());
      end
      drain_results();
   endtask

   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tvalid = 1'b0;
      csr_we     = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      mdl_reverse = 1'b0;
      mdl_thresh  = 10;
      mdl_start   = 0;
      mdl_last_t  = 0;
      mdl_pv      = 0;
      for (int k = 0; k < 3; k++) begin
         mdl_vel[k] = 0;
         mdl_pos[k] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_settings();
      test_random_drive();

      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_nav.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
design/dr3d_pkg.sv
design/dr3d_ctrl.sv
design/dr3d_datapath.sv
design/dead_reckoning_3d_step.sv
tb/testbench.sv
